// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define TOPK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TOPK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/topk_pkg.sv -----
// Package: constants and codes of the streaming top-K keeper
package topk_pkg;
	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEEP_W   = 9;
	localparam int VAL_W    = 32;
	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(256);

	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_TAKE  = 1'b1;
endpackage

// ----- hw/rtl/topk_item_if.sv -----
// Interfaces: input item channel and result channel
interface topk_item_if;
	import topk_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface topk_result_if;
	import topk_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] smallest_value;
	logic                    store_empty;

	modport source (output valid, output smallest_value, output store_empty, input ready);
	modport sink   (input valid, input smallest_value, input store_empty, output ready);
endinterface

// ----- hw/rtl/streaming_top_k_keeper_top.sv -----
// Top level: streaming top-K keeper on a sorted register chain
//
// items carries an action and a value. An offer stores the value while
// fewer than k_kept values are held; once full it replaces the smallest
// held value when strictly greater, else it is dropped. A take removes the
// smallest held value and returns it on results (0 and store_empty when
// nothing is held). An offer gives no result item.
// Each accepted item lands in an input register; from there, unless held,
// the whole chain of CAPACITY sorted cells updates in one step, one
// comparator per cell, and a take writes the result register. One item is
// accepted every cycle while no take is held by a stalled results channel.
// If results stalls, a finished take waits in the result register and the
// following item still enters the input register; a further take then
// holds there and items.ready drops until results drains.
// k_kept is written through cfg_we/cfg_wdata; the user writes it while idle,
// the block does not enforce this. Values above CAPACITY act as CAPACITY.
// Reset empties the store (count to zero), sets k_kept to 256 and drops
// the input register's valid and results.valid.
module streaming_top_k_keeper_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [topk_pkg::KEEP_W-1:0] cfg_wdata,
	topk_item_if.sink                  items,
	topk_result_if.source              results
);
	import topk_pkg::*;

	logic [KEEP_W-1:0]       k_kept_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [VAL_W-1:0] kv_q [CAPACITY];
	logic signed [VAL_W-1:0] kv_d [CAPACITY];
	logic [CAPACITY-1:0]     gt;
	logic [CAPACITY-1:0]     le;

	logic                    valid_s1;
	logic                    action_s1;
	logic signed [VAL_W-1:0] value_s1;

	logic                    res_valid_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_empty_q;

	logic [CNT_W-1:0] limit;
	logic             go;
	logic             fire;
	logic             do_insert;
	logic             do_replace;
	logic             do_take;
	logic [CNT_W-1:0] count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_kept_q <= KEEP_RESET;
		end else if (cfg_we) begin
			k_kept_q <= cfg_wdata;
		end
	end

	assign go          = !(action_s1 == ACT_TAKE && res_valid_q && !results.ready);
	assign fire        = valid_s1 && go;
	assign items.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			action_s1 <= items.action;
			value_s1  <= items.value;
		end
	end

	always_comb begin
		if (int'(k_kept_q) > CAPACITY) begin
			limit = CNT_W'(CAPACITY);
		end else begin
			limit = CNT_W'(k_kept_q);
		end
		do_insert  = fire && action_s1 == ACT_OFFER && count_q < limit;
		do_replace = fire && action_s1 == ACT_OFFER && !(count_q < limit)
			&& count_q != '0 && kv_q[0] < value_s1;
		do_take    = fire && action_s1 == ACT_TAKE && count_q != '0;

		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CNT_W'(i) >= count_q) || (value_s1 < kv_q[i]);
			le[i] = (CNT_W'(i) < count_q) && !(value_s1 < kv_q[i]);
		end

		for (int i = 0; i < CAPACITY; i++) begin
			kv_d[i] = kv_q[i];
			if (do_insert) begin
				if (gt[i]) begin
					kv_d[i] = value_s1;
					if (i > 0) begin
						if (gt[i-1]) begin
							kv_d[i] = kv_q[i-1];
						end
					end
				end
			end else if (do_replace) begin
				if (le[i]) begin
					kv_d[i] = value_s1;
				end
				if (i + 1 < CAPACITY) begin
					if (le[i+1]) begin
						kv_d[i] = kv_q[i+1];
					end
				end
			end else if (do_take) begin
				if (i + 1 < CAPACITY) begin
					kv_d[i] = kv_q[i+1];
				end
			end
		end

		count_d = count_q;
		if (do_insert) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_take) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			kv_q[i] <= kv_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && action_s1 == ACT_TAKE) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && action_s1 == ACT_TAKE) begin
			if (count_q == '0) begin
				res_value_q <= '0;
				res_empty_q <= 1'b1;
			end else begin
				res_value_q <= kv_q[0];
				res_empty_q <= 1'b0;
			end
		end
	end

	assign results.valid          = res_valid_q;
	assign results.smallest_value = res_value_q;
	assign results.store_empty    = res_empty_q;
endmodule

// ----- hw/rtl/topk_checker.sv -----
// Checker: port-level assertions for the top-K keeper, bound to the top level
`include "assert_macros.svh"

module topk_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              items_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [topk_pkg::VAL_W-1:0] res_value,
	input logic                              res_empty
);
	import topk_pkg::*;

	`TOPK_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_empty), "stalled result item changed")
	`TOPK_ASSERT(a_empty_zero, clk, arst_n, res_valid && res_empty |-> res_value == '0, "empty result with nonzero value")
	`TOPK_ASSERT(a_stall_cause, clk, arst_n, !items_ready |-> res_valid && !res_ready, "input held off while results flow")
	`TOPK_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !res_valid, "result item shown in reset")
endmodule

bind streaming_top_k_keeper_top topk_checker u_topk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.items_ready (items.ready),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_value   (results.smallest_value),
	.res_empty   (results.store_empty)
);

// ----- test/streaming_top_k_keeper_top_test.sv -----
// Testbench for the streaming top-K keeper: directed and random items checked against a predictor
`timescale 1ns / 1ps

module streaming_top_k_keeper_top_test;
	import topk_pkg::*;

	typedef struct {
		logic                    action;
		logic signed [VAL_W-1:0] value;
	} item_t;

	typedef struct {
		logic signed [VAL_W-1:0] smallest;
		logic                    empty;
	} result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [KEEP_W-1:0] cfg_wdata;

	topk_item_if   items_ch();
	topk_result_if results_ch();

	streaming_top_k_keeper_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch.sink),
		.results   (results_ch.source)
	);

	// predictor state: held values in ascending order
	logic signed [VAL_W-1:0] held_vals [CAPACITY];
	int unsigned             held_n;
	int unsigned             k_setting;

	item_t   items_pending[$];
	result_t due_results[$];
	item_t   next_item;
	result_t want;
	bit      calm_mode;
	int      queued_count;
	int      accepted_count;
	int      fail_count;
	int      offer_count;
	int      take_count;
	int      empty_takes;
	int      results_checked;
	int      peak_held;

	function automatic void drop_smallest();
		for (int i = 1; i < held_n; i++)
			held_vals[i - 1] = held_vals[i];
		if (held_n > 0)
			held_n--;
	endfunction

	function automatic void insert_value(logic signed [VAL_W-1:0] v);
		int unsigned i;
		i = held_n;
		while (i > 0 && v < held_vals[i - 1]) begin
			held_vals[i] = held_vals[i - 1];
			i--;
		end
		held_vals[i] = v;
		held_n++;
		if (held_n > peak_held)
			peak_held = held_n;
	endfunction

	function automatic void keep_offer(logic signed [VAL_W-1:0] v);
		int unsigned lim;
		lim = (k_setting > CAPACITY) ? CAPACITY : k_setting;
		if (held_n < lim) begin
			insert_value(v);
		end else if (held_n > 0 && held_vals[0] < v) begin
			drop_smallest();
			insert_value(v);
		end
	endfunction

	function automatic result_t take_smallest();
		result_t r;
		if (held_n == 0) begin
			r.smallest = '0;
			r.empty    = 1'b1;
		end else begin
			r.smallest = held_vals[0];
			r.empty    = 1'b0;
			drop_smallest();
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			1, 2, 3: return $signed(32'($urandom_range(16))) - 32'sd8;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic push_item(input logic act, input logic signed [VAL_W-1:0] v);
		item_t it;
		it.action = act;
		it.value  = v;
		items_pending.push_back(it);
		queued_count++;
	endtask

	task automatic wait_idle();
		while (queued_count != accepted_count || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_k(input logic [KEEP_W-1:0] k);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we    <= 1'b0;
		k_setting = k;
	endtask

	task automatic random_phase(input logic [KEEP_W-1:0] k, input int n, input int take_pct,
			input bit calm);
		wait_idle();
		write_k(k);
		calm_mode = calm;
		for (int i = 0; i < n; i++)
			push_item(($urandom_range(99) < take_pct) ? ACT_TAKE : ACT_OFFER, pick_value());
	endtask

	always #4 clk = ~clk;

	// sender: hold the item until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_ch.valid  <= 1'b0;
			items_ch.action <= ACT_OFFER;
			items_ch.value  <= '0;
		end else if (!items_ch.valid || items_ch.ready) begin
			if (items_pending.size() != 0 && (calm_mode || $urandom_range(99) >= 9)) begin
				next_item = items_pending.pop_front();
				items_ch.valid  <= 1'b1;
				items_ch.action <= next_item.action;
				items_ch.value  <= next_item.value;
			end else begin
				items_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_ch.ready <= 1'b0;
		else
			results_ch.ready <= calm_mode || $urandom_range(99) >= 9;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result item: smallest_value %0d, store_empty %0b",
						results_ch.smallest_value, results_ch.store_empty);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					results_checked++;
					if (results_ch.smallest_value !== want.smallest) begin
						$error("smallest_value: expected %0d, got %0d",
							want.smallest, results_ch.smallest_value);
						fail_count++;
					end
					if (results_ch.store_empty !== want.empty) begin
						$error("store_empty: expected %0b, got %0b",
							want.empty, results_ch.store_empty);
						fail_count++;
					end
				end
			end
			if (items_ch.valid && items_ch.ready) begin
				accepted_count++;
				if (items_ch.action == ACT_TAKE) begin
					want = take_smallest();
					due_results.push_back(want);
					take_count++;
					if (want.empty)
						empty_takes++;
				end else begin
					keep_offer(items_ch.value);
					offer_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		clk              = 1'b0;
		items_ch.valid   = 1'b0;
		items_ch.action  = ACT_OFFER;
		items_ch.value   = '0;
		results_ch.ready = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		arst_n           = 1'b0;
		held_n           = 0;
		k_setting        = KEEP_RESET;
		calm_mode        = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of the value range and take on an empty store
		write_k(KEEP_RESET);
		push_item(ACT_TAKE, 32'sd99);
		push_item(ACT_OFFER, 32'sh7FFF_FFFF);
		push_item(ACT_OFFER, 32'sh8000_0000);
		push_item(ACT_OFFER, 32'sd0);
		push_item(ACT_OFFER, -32'sd1);
		repeat (5) push_item(ACT_TAKE, 32'sh7FFF_FFFF);

		// equal values against a full store
		wait_idle();
		write_k(2);
		repeat (3) push_item(ACT_OFFER, 32'sd5);
		push_item(ACT_OFFER, 32'sd6);
		repeat (2) push_item(ACT_TAKE, 32'sd0);

		// fill, then lower k to zero below the count
		wait_idle();
		write_k(3);
		push_item(ACT_OFFER, 32'sd10);
		push_item(ACT_OFFER, 32'sd20);
		push_item(ACT_OFFER, 32'sd30);
		wait_idle();
		write_k(0);
		push_item(ACT_OFFER, 32'sd15);
		push_item(ACT_OFFER, 32'sd1);
		repeat (3) push_item(ACT_TAKE, 32'sd0);
		push_item(ACT_OFFER, 32'sd4);
		push_item(ACT_TAKE, 32'sd0);

		random_phase(1, 150, 30, 1'b0);
		random_phase(4, 200, 40, 1'b0);
		random_phase(17, 250, 35, 1'b0);
		random_phase(256, 500, 20, 1'b1);
		random_phase(9, 250, 55, 1'b0);
		random_phase(511, 350, 25, 1'b0);
		random_phase(0, 100, 30, 1'b0);
		random_phase(100, 50, 50, 1'b0);
		wait_idle();

		$display("Run covered %0d offers and %0d takes (%0d on an empty store) over k_kept",
			offer_count, take_count, empty_takes);
		$display("settings 0 to 511; %0d results checked, store peaked at %0d values",
			results_checked, peak_held);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
